[rtl/pl0sm_pkg.sv]
// ----------------------------------------------------------------------------
// PL/0 P-machine step unit: shared definitions
// Data widths, stack geometry, opcode and subcode names, error codes and the
// divider status bundle.
// ----------------------------------------------------------------------------
package pl0sm_pkg;

	localparam int DW          = 32;
	localparam int PCW         = 7;
	localparam int BPW         = 6;
	localparam int SPW         = 7;
	localparam int AW          = 6;
	localparam int STACK_DEPTH = 64;
	localparam int MAX_LEVEL   = 7;

	// Instruction opcodes
	localparam logic [3:0] OP_LIT = 4'd1;
	localparam logic [3:0] OP_OPR = 4'd2;
	localparam logic [3:0] OP_LOD = 4'd3;
	localparam logic [3:0] OP_STO = 4'd4;
	localparam logic [3:0] OP_CAL = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_JPC = 4'd8;
	localparam logic [3:0] OP_SYS = 4'd9;

	// OPR subcodes
	localparam logic [3:0] OPR_RTN = 4'd0;
	localparam logic [3:0] OPR_NEG = 4'd1;
	localparam logic [3:0] OPR_ADD = 4'd2;
	localparam logic [3:0] OPR_SUB = 4'd3;
	localparam logic [3:0] OPR_MUL = 4'd4;
	localparam logic [3:0] OPR_DIV = 4'd5;
	localparam logic [3:0] OPR_ODD = 4'd6;
	localparam logic [3:0] OPR_MOD = 4'd7;
	localparam logic [3:0] OPR_EQL = 4'd8;
	localparam logic [3:0] OPR_NEQ = 4'd9;
	localparam logic [3:0] OPR_LSS = 4'd10;
	localparam logic [3:0] OPR_LEQ = 4'd11;
	localparam logic [3:0] OPR_GTR = 4'd12;
	localparam logic [3:0] OPR_GEQ = 4'd13;

	// SYS subcodes
	localparam logic [DW-1:0] SYS_WRITE = 32'd1;
	localparam logic [DW-1:0] SYS_READ  = 32'd2;
	localparam logic [DW-1:0] SYS_HALT  = 32'd3;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_OPCODE  = 3'd1,
		ERR_SUBCODE = 3'd2,
		ERR_RANGE   = 3'd3,
		ERR_DIVZERO = 3'd4
	} err_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quo;
		logic [DW-1:0] rem;
	} div_res_t;

endpackage

[rtl/pl0sm_alu.sv]
// ----------------------------------------------------------------------------
// PL/0 P-machine step unit: shared arithmetic and compare unit
// Add, subtract, multiply, negate, odd and the signed compares on two words.
// ----------------------------------------------------------------------------
module pl0sm_alu (
	input  logic [3:0]               sub,
	input  logic [pl0sm_pkg::DW-1:0] a,
	input  logic [pl0sm_pkg::DW-1:0] d,
	output logic [pl0sm_pkg::DW-1:0] res
);
	import pl0sm_pkg::*;

	logic [DW-1:0] prod;
	logic [DW-1:0] odd_v;

	assign prod  = a * d;
	// remainder by two keeps the sign of the dividend
	assign odd_v = a[0] ? (a[DW-1] ? '1 : DW'(1)) : '0;

	always_comb begin
		case (sub)
			OPR_NEG: res = '0 - a;
			OPR_ADD: res = a + d;
			OPR_SUB: res = a - d;
			OPR_MUL: res = prod;
			OPR_ODD: res = odd_v;
			OPR_EQL: res = DW'(a == d);
			OPR_NEQ: res = DW'(a != d);
			OPR_LSS: res = DW'($signed(a) <  $signed(d));
			OPR_LEQ: res = DW'($signed(a) <= $signed(d));
			OPR_GTR: res = DW'($signed(a) >  $signed(d));
			OPR_GEQ: res = DW'($signed(a) >= $signed(d));
			default: res = '0;
		endcase
	end

endmodule

[rtl/pl0sm_div.sv]
// ----------------------------------------------------------------------------
// PL/0 P-machine step unit: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pl0sm_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pl0sm_pkg::DW-1:0] dividend,
	input  logic [pl0sm_pkg::DW-1:0] divisor,
	output pl0sm_pkg::div_res_t      res
);
	import pl0sm_pkg::*;

	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] ud_q;
	logic          sq_q;
	logic          sr_q;
	logic [DW:0]   rsh;
	logic          fits;

	assign rsh  = {r_q[DW-1:0], n_q[DW-1]};
	assign fits = rsh >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			r_q    <= '0;
			ud_q   <= '0;
			sq_q   <= 1'b0;
			sr_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
				n_q    <= dividend[DW-1] ? '0 - dividend : dividend;
				ud_q   <= divisor[DW-1] ? '0 - divisor : divisor;
				r_q    <= '0;
				sq_q   <= dividend[DW-1] ^ divisor[DW-1];
				sr_q   <= dividend[DW-1];
			end else if (busy_q) begin
				r_q <= fits ? rsh - {1'b0, ud_q} : rsh;
				n_q <= {n_q[DW-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quo  = sq_q ? '0 - n_q : n_q;
	assign res.rem  = sr_q ? '0 - r_q[DW-1:0] : r_q[DW-1:0];

endmodule

[rtl/pl0_stack_machine_step.sv]
// ----------------------------------------------------------------------------
// PL/0 P-machine step unit
// Executes one P-machine instruction per input transfer against an internal
// stack memory and the PC, BP and SP registers.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one instruction: func,
//   lex_level, operand_m and, for SYS read, read_value. The fetcher should
//   present the instruction stored at next_pc of the previous result.
//   The output channel (out_valid/out_ready) returns one result per
//   instruction: next_pc, frame_base_out, stack_top_out, write_value with
//   write_valid for SYS write, halted and error_code.
//   Timing: an instruction passes decode, a static link walk per lex
//   level, an address step for LOD, STO and CAL, its stack reads,
//   execute and its stack writes. DIV and MOD also wait for the
//   bit-serial divider. The stack memory port (one read and one write
//   per cycle) and the divider set the pace. in_ready is high only while
//   the sequencer is idle, so one instruction is in work at a time; the
//   next one may transfer while a result waits in the output register.
//   Reset: SP = -1, BP = 0, PC = 0, machine running; the stack reads as zero
//   through per-entry valid bits, so no clearing pass is needed.
//   Stall: a result held by out_ready low blocks only the finish of the next
//   instruction, which waits in its last state until the register drains.
//   Once halted (SYS halt or any fault) the state freezes and every further
//   instruction reports the held PC, BP and SP with halted set.
// ----------------------------------------------------------------------------
module pl0_stack_machine_step (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [3:0]                       func,
	input  logic [2:0]                       lex_level,
	input  logic signed [pl0sm_pkg::DW-1:0]  operand_m,
	input  logic signed [pl0sm_pkg::DW-1:0]  read_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pl0sm_pkg::PCW-1:0]        next_pc,
	output logic [pl0sm_pkg::BPW-1:0]        frame_base_out,
	output logic signed [pl0sm_pkg::SPW-1:0] stack_top_out,
	output logic signed [pl0sm_pkg::DW-1:0]  write_value,
	output logic                             write_valid,
	output logic                             halted,
	output logic [2:0]                       error_code
);
	import pl0sm_pkg::*;

	localparam int XW  = SPW + 2;   // SP arithmetic with headroom
	localparam int XMW = DW + 2;    // SP or base plus a full operand

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_DEC   = 11'b00000000010,
		S_WALK  = 11'b00000000100,
		S_WALKD = 11'b00000001000,
		S_ADDR  = 11'b00000010000,
		S_RD    = 11'b00000100000,
		S_RDD   = 11'b00001000000,
		S_EXEC  = 11'b00010000000,
		S_DIVW  = 11'b00100000000,
		S_WR    = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	function automatic logic in_stk(input logic signed [XW-1:0] x);
		in_stk = (x >= 0) && (x < $signed(XW'(STACK_DEPTH)));
	endfunction

	// Architectural state
	state_t                state_q;
	logic [PCW-1:0]        pc_q;
	logic [BPW-1:0]        bp_q;
	logic signed [SPW-1:0] sp_q;
	logic                  stopped_q;

	// Held instruction and work registers
	logic [3:0]    func_q;
	logic [2:0]    lvl_q;
	logic [DW-1:0] m_q;
	logic [DW-1:0] rv_q;
	logic [AW-1:0] b_q;
	logic [2:0]    cnt_q;
	logic [AW-1:0] ea_q;
	logic [1:0]    rd_idx_q;
	logic [1:0]    nrd_q;
	logic [2:0]    wr_idx_q;
	logic [2:0]    nwr_q;
	logic [DW-1:0] v_q [3];
	logic [DW-1:0] r_q;
	err_t          err_q;

	// Output register
	logic          out_valid_q;
	logic [DW-1:0] wv_o_q;
	logic          wvld_o_q;
	err_t          err_o_q;

	// Stack memory with per-entry valid bits
	logic [DW-1:0]          mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] vld_q;
	logic [DW-1:0]          mrd_q;
	logic                   mrv_q;
	logic [DW-1:0]          mem_data;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [DW-1:0]          wr_data;

	// Decode
	logic [3:0]              sub;
	logic                    opr_ok;
	logic                    is_opr0;
	logic                    is_opr1;
	logic                    is_div;
	logic                    sys_w;
	logic                    sys_r;
	logic                    sys_h;
	logic signed [XW-1:0]    spx;
	logic signed [XW-1:0]    bpx;
	logic signed [XMW-1:0]   sp_m;
	logic signed [XMW-1:0]   b_m;
	logic                    cal_copy;
	logic [AW-1:0]           sp_a;
	logic [PCW-1:0]          pc_p1;
	logic                    slot_free;
	logic [DW-1:0]           alu_res;
	div_res_t                div_res;
	logic                    div_start;
	logic [1:0]              nrd_d;
	logic [2:0]              nwr_d;

	// Next architectural values, used when the instruction retires
	logic [PCW-1:0]        npc;
	logic [BPW-1:0]        nbp;
	logic signed [SPW-1:0] nsp;

	assign sub      = m_q[3:0];
	assign opr_ok   = (m_q[DW-1:4] == '0) && (sub <= OPR_GEQ);
	assign is_opr0  = (sub == OPR_RTN);
	assign is_opr1  = (sub == OPR_NEG) || (sub == OPR_ODD);
	assign is_div   = (sub == OPR_DIV) || (sub == OPR_MOD);
	assign sys_w    = (m_q == SYS_WRITE);
	assign sys_r    = (m_q == SYS_READ);
	assign sys_h    = (m_q == SYS_HALT);
	assign spx      = XW'(sp_q);
	assign bpx      = $signed({{(XW - BPW){1'b0}}, bp_q});
	assign sp_m     = XMW'(sp_q) + XMW'($signed(m_q));
	assign b_m      = $signed({{(XMW - AW){1'b0}}, b_q}) + XMW'($signed(m_q));
	assign cal_copy = !sp_q[SPW-1] && in_stk(spx + XW'(4));
	assign sp_a     = sp_q[AW-1:0];
	assign pc_p1    = pc_q + 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	// Read and write counts per instruction
	always_comb begin
		nrd_d = 2'd0;
		nwr_d = 3'd0;
		case (func_q)
			OP_LIT: nwr_d = 3'd1;
			OP_OPR: begin
				nrd_d = is_opr0 ? 2'd3 : (is_opr1 ? 2'd1 : 2'd2);
				nwr_d = 3'd1;
			end
			OP_LOD, OP_STO: begin
				nrd_d = 2'd1;
				nwr_d = 3'd1;
			end
			OP_CAL: begin
				nrd_d = sp_q[SPW-1] ? 2'd0 : 2'd1;
				nwr_d = cal_copy ? 3'd4 : 3'd3;
			end
			OP_JPC: nrd_d = 2'd1;
			OP_SYS: begin
				nrd_d = sys_w ? 2'd1 : 2'd0;
				nwr_d = sys_r ? 3'd1 : 3'd0;
			end
			default: ;
		endcase
	end

	// Read address: static link walk, then the operand reads
	always_comb begin
		rd_en   = (state_q == S_WALK) || ((state_q == S_RD) && (rd_idx_q != nrd_q));
		rd_addr = sp_a;
		if (state_q == S_WALK) begin
			rd_addr = b_q;
		end else if (func_q == OP_OPR && is_opr0) begin
			case (rd_idx_q)
				2'd0:    rd_addr = bp_q + AW'(1);
				2'd1:    rd_addr = bp_q + AW'(2);
				default: rd_addr = sp_a;
			endcase
		end else if (func_q == OP_OPR && !is_opr1 && rd_idx_q == 2'd0) begin
			rd_addr = sp_a - AW'(1);
		end else if (func_q == OP_LOD) begin
			rd_addr = ea_q;
		end
	end

	// Write address and data
	always_comb begin
		wr_en   = (state_q == S_WR) && (wr_idx_q != nwr_q);
		wr_addr = sp_a + AW'(1);
		wr_data = m_q;
		case (func_q)
			OP_LIT: ;
			OP_OPR: begin
				if (is_opr0) begin
					wr_addr = bp_q - AW'(1);
					wr_data = v_q[2];
				end else if (is_opr1) begin
					wr_addr = sp_a;
					wr_data = r_q;
				end else begin
					wr_addr = sp_a - AW'(1);
					wr_data = r_q;
				end
			end
			OP_LOD: wr_data = v_q[0];
			OP_STO: begin
				wr_addr = ea_q;
				wr_data = v_q[0];
			end
			OP_CAL: begin
				case (wr_idx_q)
					3'd0: wr_data = DW'(b_q);
					3'd1: begin
						wr_addr = sp_a + AW'(2);
						wr_data = DW'(bp_q);
					end
					3'd2: begin
						wr_addr = sp_a + AW'(3);
						wr_data = DW'(pc_p1);
					end
					default: begin
						wr_addr = sp_a + AW'(4);
						wr_data = v_q[0];
					end
				endcase
			end
			default: wr_data = rv_q;
		endcase
	end

	// Retire values
	always_comb begin
		npc = pc_p1;
		nbp = bp_q;
		nsp = sp_q;
		case (func_q)
			OP_LIT, OP_LOD: nsp = sp_q + SPW'(1);
			OP_OPR: begin
				if (is_opr0) begin
					npc = v_q[1][PCW-1:0];
					nbp = v_q[0][BPW-1:0];
					nsp = $signed(SPW'(bp_q)) - SPW'(1);
				end else if (!is_opr1) begin
					nsp = sp_q - SPW'(1);
				end
			end
			OP_STO: nsp = sp_q - SPW'(1);
			OP_CAL: begin
				npc = m_q[PCW-1:0];
				nbp = BPW'(sp_q + SPW'(1));
			end
			OP_INC: nsp = sp_m[SPW-1:0];
			OP_JMP: npc = m_q[PCW-1:0];
			OP_JPC: begin
				if (v_q[0] == '0) begin
					npc = m_q[PCW-1:0];
				end
				nsp = sp_q - SPW'(1);
			end
			OP_SYS: begin
				if (sys_w) begin
					nsp = sp_q - SPW'(1);
				end else if (sys_r) begin
					nsp = sp_q + SPW'(1);
				end
			end
			default: ;
		endcase
	end

	assign mem_data  = mrv_q ? mrd_q : '0;
	assign div_start = (state_q == S_EXEC) && (func_q == OP_OPR) && is_div &&
		(v_q[1] != '0);

	pl0sm_alu u_alu (
		.sub (sub),
		.a   (v_q[0]),
		.d   (v_q[1]),
		.res (alu_res)
	);

	pl0sm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q[0]),
		.divisor  (v_q[1]),
		.res      (div_res)
	);

	// Stack memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mrd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			mrv_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				mrv_q <= vld_q[rd_addr];
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			bp_q        <= '0;
			sp_q        <= '1;
			stopped_q   <= 1'b0;
			func_q      <= '0;
			lvl_q       <= '0;
			m_q         <= '0;
			rv_q        <= '0;
			b_q         <= '0;
			cnt_q       <= '0;
			ea_q        <= '0;
			rd_idx_q    <= '0;
			nrd_q       <= '0;
			wr_idx_q    <= '0;
			nwr_q       <= '0;
			v_q[0]      <= '0;
			v_q[1]      <= '0;
			v_q[2]      <= '0;
			r_q         <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
			wv_o_q      <= '0;
			wvld_o_q    <= 1'b0;
			err_o_q     <= ERR_OK;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// take the next instruction
					if (in_valid) begin
						func_q  <= func;
						lvl_q   <= lex_level;
						m_q     <= operand_m;
						rv_q    <= read_value;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					// check operands against the stack before touching anything
					err_q    <= ERR_OK;
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					nrd_q    <= nrd_d;
					nwr_q    <= nwr_d;
					b_q      <= bp_q;
					cnt_q    <= lvl_q;
					state_q  <= S_RD;
					if (stopped_q) begin
						state_q <= S_DONE;
					end else begin
						case (func_q)
							OP_LIT: begin
								if (!in_stk(spx + XW'(1))) begin
									err_q   <= ERR_RANGE;
									state_q <= S_DONE;
								end
							end
							OP_OPR: begin
								if (!opr_ok) begin
									err_q   <= ERR_SUBCODE;
									state_q <= S_DONE;
								end else if (is_opr0) begin
									if (!in_stk(spx) || !in_stk(bpx - XW'(1)) ||
										!in_stk(bpx + XW'(2))) begin
										err_q   <= ERR_RANGE;
										state_q <= S_DONE;
									end
								end else if (is_opr1) begin
									if (!in_stk(spx)) begin
										err_q   <= ERR_RANGE;
										state_q <= S_DONE;
									end
								end else if (!in_stk(spx) || !in_stk(spx - XW'(1))) begin
									err_q   <= ERR_RANGE;
									state_q <= S_DONE;
								end
							end
							OP_LOD, OP_STO, OP_CAL: begin
								if ((func_q == OP_LOD && !in_stk(spx + XW'(1))) ||
									(func_q == OP_STO && !in_stk(spx)) ||
									(func_q == OP_CAL && !in_stk(spx + XW'(3))) ||
									(32'(lvl_q) > MAX_LEVEL)) begin
									err_q   <= ERR_RANGE;
									state_q <= S_DONE;
								end else begin
									state_q <= (lvl_q != '0) ? S_WALK : S_ADDR;
								end
							end
							OP_INC: begin
								if (sp_m < -XMW'(1) || sp_m >= $signed(XMW'(STACK_DEPTH))) begin
									err_q   <= ERR_RANGE;
									state_q <= S_DONE;
								end
							end
							OP_JMP: ;
							OP_JPC: begin
								if (!in_stk(spx)) begin
									err_q   <= ERR_RANGE;
									state_q <= S_DONE;
								end
							end
							OP_SYS: begin
								if (sys_w) begin
									if (!in_stk(spx)) begin
										err_q   <= ERR_RANGE;
										state_q <= S_DONE;
									end
								end else if (sys_r) begin
									if (!in_stk(spx + XW'(1))) begin
										err_q   <= ERR_RANGE;
										state_q <= S_DONE;
									end
								end else if (!sys_h) begin
									err_q   <= ERR_SUBCODE;
									state_q <= S_DONE;
								end
							end
							default: begin
								err_q   <= ERR_OPCODE;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					// read the static link at the current base
					state_q <= S_WALKD;
				end
				S_WALKD: begin
					if (mem_data[DW-1:AW] != '0) begin
						err_q   <= ERR_RANGE;
						state_q <= S_DONE;
					end else begin
						b_q   <= mem_data[AW-1:0];
						cnt_q <= cnt_q - 1'b1;
						state_q <= (cnt_q == 3'd1) ? S_ADDR : S_WALK;
					end
				end
				S_ADDR: begin
					ea_q    <= b_m[AW-1:0];
					state_q <= S_RD;
					if (func_q != OP_CAL &&
						(b_m < 0 || b_m >= $signed(XMW'(STACK_DEPTH)))) begin
						err_q   <= ERR_RANGE;
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= (rd_idx_q == nrd_q) ? S_EXEC : S_RDD;
				end
				S_RDD: begin
					v_q[rd_idx_q] <= mem_data;
					rd_idx_q      <= rd_idx_q + 1'b1;
					state_q       <= S_RD;
					// the restored base must lie inside the stack
					if (func_q == OP_OPR && is_opr0 && rd_idx_q == 2'd0 &&
						mem_data[DW-1:AW] != '0) begin
						err_q   <= ERR_RANGE;
						state_q <= S_DONE;
					end
				end
				S_EXEC: begin
					r_q     <= alu_res;
					state_q <= S_WR;
					if (func_q == OP_OPR && is_div) begin
						if (v_q[1] == '0) begin
							err_q   <= ERR_DIVZERO;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIVW;
						end
					end
				end
				S_DIVW: begin
					if (div_res.done) begin
						r_q     <= (sub == OPR_MOD) ? div_res.rem : div_res.quo;
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (wr_idx_q == nwr_q) begin
						state_q <= S_DONE;
					end else begin
						wr_idx_q <= wr_idx_q + 1'b1;
					end
				end
				S_DONE: begin
					// retire once the output register can take the result
					if (slot_free) begin
						out_valid_q <= 1'b1;
						wvld_o_q    <= 1'b0;
						wv_o_q      <= '0;
						err_o_q     <= ERR_OK;
						state_q     <= S_IDLE;
						if (!stopped_q) begin
							if (err_q != ERR_OK) begin
								stopped_q <= 1'b1;
								err_o_q   <= err_q;
							end else begin
								pc_q <= npc;
								bp_q <= nbp;
								sp_q <= nsp;
								if (func_q == OP_SYS && sys_h) begin
									stopped_q <= 1'b1;
								end
								if (func_q == OP_SYS && sys_w) begin
									wvld_o_q <= 1'b1;
									wv_o_q   <= v_q[0];
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign next_pc        = pc_q;
	assign frame_base_out = bp_q;
	assign stack_top_out  = sp_q;
	assign write_value    = $signed(wv_o_q);
	assign write_valid    = wvld_o_q;
	assign halted         = stopped_q;
	assign error_code     = err_o_q;

	// A stopped machine never changes its PC, BP and SP registers
	a_stopped_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> $stable(pc_q) && $stable(bp_q) && $stable(sp_q) && stopped_q)
		else $error("state moved after stop");

	// No stack write once stopped
	a_no_write_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !stopped_q)
		else $error("stack written while stopped");

	// A faulting result always reports a stop
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> halted && !write_valid)
		else $error("fault reported without stop");

	// SP is either empty or a stack index
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!sp_q[SPW-1] || sp_q == '1)
		else $error("stack pointer below empty");

endmodule
